FILE: hw/rtl/rss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the random sample set
// Opcodes, status codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rss_pkg;

    // default table size
    localparam int CAPACITY_DEF = 64;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;

    // restoring divider: one quotient bit per step
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // request opcodes (code 3 has no meaning)
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SAMPLE = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_CMP,
        S_APPEND,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DIV,
        S_SMP_RSP
    } t_state;

    // table read address source
    typedef enum logic [1:0] {
        AS_IDX,
        AS_LAST,
        AS_REM
    } t_addr_sel;

    // table write source: append at the end, or move last entry into hole
    typedef enum logic {
        WS_APPEND,
        WS_MOVE
    } t_wr_sel;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      scan_clr;
        logic      scan_inc;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      wr_en;
        t_wr_sel   wr_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      div_start;
        logic      div_step;
        logic      respond;
        t_status   resp_status;
        logic      resp_sample;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            last;
        logic            empty;
        logic            full;
        logic            div_done;
    } t_dp_sts;

endpackage

FILE: hw/rtl/rss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_ctrl: request sequencer
// Walks each request through scan, update, divide and respond steps and
// drives the datapath with one command word per cycle.
// ----------------------------------------------------------------------------
module rss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rss_pkg::t_dp_sts i_sts,
    output rss_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    rss_pkg::t_state r_state;
    rss_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rss_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = rss_pkg::S_DISPATCH;
                end
            end

            rss_pkg::S_DISPATCH: begin
                o_cmd.scan_clr = 1'b1;
                case (i_sts.op)
                    rss_pkg::OP_INSERT: begin
                        n_state = i_sts.empty ? rss_pkg::S_APPEND : rss_pkg::S_READ;
                    end
                    rss_pkg::OP_REMOVE: begin
                        if (i_sts.empty) begin
                            o_cmd.respond     = 1'b1;
                            o_cmd.resp_status = rss_pkg::ST_REJECT;
                            n_state           = rss_pkg::S_IDLE;
                        end else begin
                            n_state = rss_pkg::S_READ;
                        end
                    end
                    rss_pkg::OP_SAMPLE: begin
                        if (i_sts.empty) begin
                            o_cmd.respond     = 1'b1;
                            o_cmd.resp_status = rss_pkg::ST_EMPTY;
                            n_state           = rss_pkg::S_IDLE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = rss_pkg::S_DIV;
                        end
                    end
                    default: begin
                        // unknown opcode: nothing changes
                        o_cmd.respond     = 1'b1;
                        o_cmd.resp_status = rss_pkg::ST_REJECT;
                        n_state           = rss_pkg::S_IDLE;
                    end
                endcase
            end

            // fetch the entry under the scan index
            rss_pkg::S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rss_pkg::AS_IDX;
                n_state      = rss_pkg::S_CMP;
            end

            // compare it with the request value
            rss_pkg::S_CMP: begin
                if (i_sts.hit) begin
                    if (i_sts.op == rss_pkg::OP_REMOVE) begin
                        n_state = rss_pkg::S_MOVE_RD;
                    end else begin
                        o_cmd.respond     = 1'b1;
                        o_cmd.resp_status = rss_pkg::ST_REJECT;
                        n_state           = rss_pkg::S_IDLE;
                    end
                end else if (i_sts.last) begin
                    if (i_sts.op == rss_pkg::OP_INSERT && !i_sts.full) begin
                        n_state = rss_pkg::S_APPEND;
                    end else begin
                        o_cmd.respond     = 1'b1;
                        o_cmd.resp_status = (i_sts.op == rss_pkg::OP_INSERT) ?
                                            rss_pkg::ST_FULL : rss_pkg::ST_REJECT;
                        n_state           = rss_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = rss_pkg::S_READ;
                end
            end

            rss_pkg::S_APPEND: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_sel      = rss_pkg::WS_APPEND;
                o_cmd.cnt_inc     = 1'b1;
                o_cmd.respond     = 1'b1;
                o_cmd.resp_status = rss_pkg::ST_DONE;
                n_state           = rss_pkg::S_IDLE;
            end

            // removal: fetch the last entry, then drop it into the hole
            rss_pkg::S_MOVE_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rss_pkg::AS_LAST;
                n_state      = rss_pkg::S_MOVE_WR;
            end

            rss_pkg::S_MOVE_WR: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_sel      = rss_pkg::WS_MOVE;
                o_cmd.cnt_dec     = 1'b1;
                o_cmd.respond     = 1'b1;
                o_cmd.resp_status = rss_pkg::ST_DONE;
                n_state           = rss_pkg::S_IDLE;
            end

            // divide; on completion read the entry at the remainder
            rss_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = rss_pkg::AS_REM;
                    n_state      = rss_pkg::S_SMP_RSP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end

            rss_pkg::S_SMP_RSP: begin
                o_cmd.respond     = 1'b1;
                o_cmd.resp_status = rss_pkg::ST_DONE;
                o_cmd.resp_sample = 1'b1;
                n_state           = rss_pkg::S_IDLE;
            end

            default: begin
                n_state = rss_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rss_pkg::S_IDLE);

endmodule

FILE: hw/rtl/rss_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_dpath: set storage and arithmetic
// Member table RAM, member count, scan index, bit-serial restoring
// divider for the sample index, and the result register.
// ----------------------------------------------------------------------------
module rss_dpath #(
    parameter int CAPACITY = rss_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rss_pkg::t_dp_cmd                     i_cmd,
    output rss_pkg::t_dp_sts                     o_sts,
    input  logic [rss_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [rss_pkg::DATA_W-1:0]    i_value,
    input  logic [rss_pkg::DATA_W-1:0]           i_random_word,
    output logic                                 o_done,
    output logic [rss_pkg::ST_W-1:0]             o_status,
    output logic signed [rss_pkg::DATA_W-1:0]    o_sampled_value,
    output logic [$clog2(CAPACITY+1)-1:0]        o_member_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request registers
    logic [rss_pkg::OP_W-1:0]   r_op;
    logic [rss_pkg::DATA_W-1:0] r_value;

    // control state
    logic [CNT_W-1:0]              r_count, n_count;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [rss_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                          r_done;

    // divider and result payload
    logic [CNT_W-1:0]           r_rem, n_rem;
    logic [rss_pkg::DATA_W-1:0] r_dvd, n_dvd;
    logic [rss_pkg::ST_W-1:0]   r_status;
    logic [rss_pkg::DATA_W-1:0] r_sampled;

    // table ports
    logic [IDX_W-1:0]           rd_addr, wr_addr;
    logic [rss_pkg::DATA_W-1:0] wr_data, rd_data;
    logic [CNT_W-1:0]           cnt_m1;
    logic [CNT_W:0]             rem_sh;
    logic [CNT_W:0]             cnt_ext;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign rem_sh  = {r_rem, r_dvd[rss_pkg::DATA_W-1]};
    assign cnt_ext = {1'b0, r_count};

    // table address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            rss_pkg::AS_LAST: rd_addr = cnt_m1[IDX_W-1:0];
            rss_pkg::AS_REM:  rd_addr = r_rem[IDX_W-1:0];
            default:          rd_addr = r_idx;
        endcase
        if (i_cmd.wr_sel == rss_pkg::WS_MOVE) begin
            wr_addr = r_idx;
            wr_data = rd_data;
        end else begin
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_value;
        end
    end

    rss_ram #(
        .WIDTH (rss_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // count, scan index and divider next values
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = cnt_m1;
        end
        if (i_cmd.scan_clr) begin
            n_idx = '0;
        end else if (i_cmd.scan_inc) begin
            n_idx = r_idx + IDX_W'(1);
        end
        if (i_cmd.load) begin
            n_dvd = i_random_word;
        end
        if (i_cmd.div_start) begin
            n_rem     = '0;
            n_div_cnt = rss_pkg::DIV_CNT_W'(rss_pkg::DIV_STEPS);
        end else if (i_cmd.div_step) begin
            // one restoring step: shift in the next dividend bit
            if (rem_sh >= cnt_ext) begin
                n_rem = CNT_W'(rem_sh - cnt_ext);
            end else begin
                n_rem = rem_sh[CNT_W-1:0];
            end
            n_dvd     = r_dvd << 1;
            n_div_cnt = r_div_cnt - rss_pkg::DIV_CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_div_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_div_cnt <= n_div_cnt;
            r_done    <= i_cmd.respond;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (i_cmd.respond) begin
            r_status  <= i_cmd.resp_status;
            r_sampled <= i_cmd.resp_sample ? rd_data : '0;
        end
    end

    // status back to the controller
    assign o_sts.op       = r_op;
    assign o_sts.hit      = (rd_data == r_value);
    assign o_sts.last     = (r_idx == cnt_m1[IDX_W-1:0]);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CNT_W'(CAPACITY));
    assign o_sts.div_done = (r_div_cnt == '0);

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_sampled_value = r_sampled;
    assign o_member_count  = r_count;

endmodule

FILE: hw/rtl/random_sample_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_sample_set_top: set of distinct 32-bit values with random sampling
// Insert, remove and sample requests over a dense member table searched
// entry by entry; sample index is random_word modulo the member count.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Word
//  request   in         i_start high, o_busy low  i_opcode, i_value, i_random_word
//  result    out        o_done strobe, one cycle  o_status, o_sampled_value,
//                                                 o_member_count
//
//  Sample: the 32-step divider runs, then the entry at the remainder is read and returned.
//  Search: each entry examined is read and then compared; the search ends by
//  settling the word, or goes on to an append or to a removal's move.
//  Empty-set remove or sample and the unused opcode are answered from dispatch.
//  Reset: i_rst_n synchronous, clears the member count and the controller.
//  o_busy is low again in the o_done cycle; the receiver cannot stall.
//
module random_sample_set_top #(
    parameter int CAPACITY = rss_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [rss_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [rss_pkg::DATA_W-1:0]    i_value,
    input  logic [rss_pkg::DATA_W-1:0]           i_random_word,
    output logic                                 o_done,
    output logic [rss_pkg::ST_W-1:0]             o_status,
    output logic signed [rss_pkg::DATA_W-1:0]    o_sampled_value,
    output logic [$clog2(CAPACITY+1)-1:0]        o_member_count
);

    rss_pkg::t_dp_cmd cmd;
    rss_pkg::t_dp_sts sts;

    // sequencer
    rss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // storage and arithmetic
    rss_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_random_word   (i_random_word),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_sampled_value (o_sampled_value),
        .o_member_count  (o_member_count)
    );

    // result strobe only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while sequencer busy");

    // the member count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_member_count <= CAPACITY)
        else $error("member count beyond capacity");

    // a failed request leaves the member count alone
    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != rss_pkg::ST_DONE) |-> $stable(o_member_count))
        else $error("failed request changed the member count");

    // a failed request returns no sampled value
    a_fail_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != rss_pkg::ST_DONE) |-> (o_sampled_value == '0))
        else $error("failed request returned a sampled value");

endmodule
